>>> src/wildcard_byte_signature_scan_unit_macros.svh
// Assertion helpers for the signature scanner.
// Each check is compiled only for simulation and is empty in synthesis.
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_UNIT_MACROS_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define WBSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wbss check failed");
`define WBSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wbss check failed");
`else
`define WBSS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define WBSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/wbss_pkg.sv
package wbss_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_PATTERN_BYTES_DEF = 32;
  localparam int OFFSET_BITS_DEF       = 32;

  // Fixed widths of the register file and the pattern storage.
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int WORD_BYTES = 32;
  localparam int LEN_W      = 6;
  localparam int COUNT_W    = 32;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_SECOND = 3'd1,
    CFG_PATTERN_THIRD  = 3'd2,
    CFG_PATTERN_HIGH   = 3'd3,
    CFG_WILDCARD_MASK  = 3'd4,
    CFG_PATTERN_LENGTH = 3'd5,
    CFG_ALLOWED        = 3'd6,
    CFG_REGION_BASE    = 3'd7
  } cfg_idx_e;

  // Scan status codes.
  localparam logic [1:0] STATUS_NONE = 2'd0;
  localparam logic [1:0] STATUS_FOUND = 2'd1;
  localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

  // Input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [1:0]  scan_status;
    logic [63:0] match_address;
    logic [31:0] match_total;
  } out_t;

  // Per-cell reference: which pattern byte this window slot is checked against.
  typedef struct packed {
    logic       active;
    logic       wild;
    logic [7:0] pat;
  } cell_ref_t;

endpackage

>>> src/wbss_cell.sv
module wbss_cell (
  input  logic                clk_i,
  input  logic                shift_i,
  input  logic [7:0]          byte_i,
  input  wbss_pkg::cell_ref_t ref_i,
  output logic [7:0]          byte_o,
  output logic                match_o
);

  logic [7:0] byte_q;

  // One window slot; it takes the byte of its newer neighbor on every shift.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

  // A slot outside the pattern or under a wildcard always agrees.
  assign match_o = !ref_i.active || ref_i.wild || (byte_q == ref_i.pat);

endmodule

>>> src/wildcard_byte_signature_scan_unit.sv
// Wildcard byte signature scanner.
// Input channel: one byte of a memory region per transaction, with a mark on
// the final byte. Configuration: a write port with enable, register index and
// 64-bit data; the user writes it only while no region is in progress, which
// the block itself does not enforce. Output channel: one result transaction per
// region, produced after its final byte: status, base address plus offset of
// the first match (zero unless found), and match count. Throughput is one byte
// per cycle while no held result is stalled. The window is a chain of byte
// cells that shift once per accepted byte and are all compared in parallel in
// the cycle after; a region's result goes via stage 2 to the output register.
// When the receiver stalls while a result is held, the whole pipeline holds
// and the input stall rises in the same cycle; nothing is dropped.
// Reset clears the scan state and loads the register defaults (length 1,
// allowed matches 1, everything else zero). After each final byte the scan
// state returns to zero; the registers keep their values.
`include "wildcard_byte_signature_scan_unit_macros.svh"

module wildcard_byte_signature_scan_unit #(
  parameter int MAX_PATTERN_BYTES = wbss_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS       = wbss_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  wbss_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output wbss_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [wbss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wbss_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int LenLimit = (MAX_PATTERN_BYTES < wbss_pkg::WORD_BYTES) ?
                            MAX_PATTERN_BYTES : wbss_pkg::WORD_BYTES;
  localparam int OffW = (OFFSET_BITS < wbss_pkg::COUNT_W) ? OFFSET_BITS : wbss_pkg::COUNT_W;
  localparam int CntW = wbss_pkg::COUNT_W;
  localparam int LenW = wbss_pkg::LEN_W;

  // Configuration registers.
  logic [wbss_pkg::WORD_BYTES-1:0][7:0] pat_q;
  logic [31:0]                          mask_q;
  logic [LenW-1:0]                      len_q;
  logic [7:0]                           allowed_q;
  logic [63:0]                          base_q;

  // Pipeline control.
  logic            adv;
  logic            in_acc;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_inc;
  logic            s1_valid_q;
  logic            s1_last_q;
  logic [CntW-1:0] s1_seen_q;
  logic [CntW-1:0] match_cnt_q;
  logic [CntW-1:0] match_cnt_d;
  logic [OffW-1:0] first_off_q;
  logic [OffW-1:0] first_off_d;
  logic            r_valid_q;
  logic [CntW-1:0] r_cnt_q;
  logic [OffW-1:0] r_off_q;
  logic            out_valid_q;
  wbss_pkg::out_t  out_data_q;
  wbss_pkg::out_t  out_data_d;

  // Window and compare.
  logic [LenW-1:0]         len_used;
  logic [LenLimit:0][7:0]  chain;
  logic [LenLimit-1:0]     cell_match;
  logic                    window_hit;
  logic [CntW-1:0]         offset_full;

  // The pipeline moves unless a held result is stalled.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && adv;
  assign in_stall_o = !adv;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q     <= '0;
      mask_q    <= '0;
      len_q     <= LenW'(1);
      allowed_q <= 8'd1;
      base_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (wbss_pkg::cfg_idx_e'(cfg_idx_i))
        wbss_pkg::CFG_PATTERN_LOW:    pat_q[7:0]   <= cfg_wdata_i;
        wbss_pkg::CFG_PATTERN_SECOND: pat_q[15:8]  <= cfg_wdata_i;
        wbss_pkg::CFG_PATTERN_THIRD:  pat_q[23:16] <= cfg_wdata_i;
        wbss_pkg::CFG_PATTERN_HIGH:   pat_q[31:24] <= cfg_wdata_i;
        wbss_pkg::CFG_WILDCARD_MASK:  mask_q       <= cfg_wdata_i[31:0];
        wbss_pkg::CFG_PATTERN_LENGTH: len_q        <= cfg_wdata_i[LenW-1:0];
        wbss_pkg::CFG_ALLOWED:        allowed_q    <= cfg_wdata_i[7:0];
        wbss_pkg::CFG_REGION_BASE:    base_q       <= cfg_wdata_i;
      endcase
    end
  end

  // Pattern length clamped to the supported range.
  always_comb begin
    len_used = len_q;
    if (len_q == '0) begin
      len_used = LenW'(1);
    end else if (len_q > LenW'(LenLimit)) begin
      len_used = LenW'(LenLimit);
    end
  end

  // Chain of window cells; slot 0 holds the newest byte. Slot j is checked
  // against pattern byte len-1-j while j is inside the pattern.
  assign chain[0] = in_data_i.data_byte;

  for (genvar j = 0; j < LenLimit; j++) begin : g_cell
    logic [LenW-1:0]     k;
    wbss_pkg::cell_ref_t cref;

    assign k           = len_used - LenW'(1) - LenW'(j);
    assign cref.active = LenW'(j) < len_used;
    assign cref.wild   = mask_q[k[4:0]];
    assign cref.pat    = pat_q[k[4:0]];

    wbss_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (in_acc),
      .byte_i  (chain[j]),
      .ref_i   (cref),
      .byte_o  (chain[j+1]),
      .match_o (cell_match[j])
    );
  end

  // Stage 1: count bytes of the region, saturating.
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_acc;
      if (in_acc) begin
        cnt_q <= in_data_i.last_byte ? '0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_last_q <= in_data_i.last_byte;
      s1_seen_q <= cnt_inc;
    end
  end

  // Stage 2: full-window compare and match bookkeeping.
  assign window_hit  = (&cell_match) && (s1_seen_q >= CntW'(len_used));
  assign offset_full = s1_seen_q - CntW'(len_used);

  always_comb begin
    match_cnt_d = match_cnt_q;
    first_off_d = first_off_q;
    if (window_hit) begin
      if (match_cnt_q == '0) begin
        first_off_d = offset_full[OffW-1:0];
      end
      if (match_cnt_q != '1) begin
        match_cnt_d = match_cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_cnt_q <= '0;
      first_off_q <= '0;
      r_valid_q   <= 1'b0;
    end else if (adv) begin
      r_valid_q <= s1_valid_q && s1_last_q;
      if (s1_valid_q) begin
        match_cnt_q <= s1_last_q ? '0 : match_cnt_d;
        first_off_q <= s1_last_q ? '0 : first_off_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q && s1_last_q) begin
      r_cnt_q <= match_cnt_d;
      r_off_q <= first_off_d;
    end
  end

  // Stage 3: status and address into the output register.
  always_comb begin
    out_data_d.match_total   = r_cnt_q;
    out_data_d.match_address = '0;
    if (r_cnt_q == '0) begin
      out_data_d.scan_status = wbss_pkg::STATUS_NONE;
    end else if (r_cnt_q > CntW'(allowed_q)) begin
      out_data_d.scan_status = wbss_pkg::STATUS_TOO_MANY;
    end else begin
      out_data_d.scan_status   = wbss_pkg::STATUS_FOUND;
      out_data_d.match_address = base_q + 64'(r_off_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && r_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A zero count goes with the not-found status and with no other.
  `WBSS_ASSERT_SAME(a_none_iff_zero, clk_i, rst_ni, out_valid_o,
                    (out_data_o.match_total == '0) ==
                    (out_data_o.scan_status == wbss_pkg::STATUS_NONE))
  // Only a found status carries an address.
  `WBSS_ASSERT_SAME(a_addr_only_found, clk_i, rst_ni,
                    out_valid_o && (out_data_o.scan_status != wbss_pkg::STATUS_FOUND),
                    out_data_o.match_address == '0)
  // A held, stalled result stops the input side.
  `WBSS_ASSERT_SAME(a_stall_back, clk_i, rst_ni, out_valid_q && out_stall_i, in_stall_o)
  // The match state starts over after a final byte.
  `WBSS_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, adv && s1_valid_q && s1_last_q,
                    (match_cnt_q == '0) && (first_off_q == '0))

endmodule
